/* rtl/sorted_array_priority_queue_macros.svh */
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_macros
// Assertion macros used by the checker file of the priority queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SAPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SAPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sapq_pkg.sv */
// ----------------------------------------------------------------------------
// sapq_pkg
// Types and codes shared by the sorted-array priority queue.
// ----------------------------------------------------------------------------
package sapq_pkg;

  localparam int unsigned PrioW    = 16;
  localparam int unsigned PayloadW = 32;
  localparam int unsigned CountW   = 5;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [PrioW-1:0]    prio;
    logic [PayloadW-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

/* rtl/sapq_if.sv */
// ----------------------------------------------------------------------------
// sapq_in_if / sapq_out_if
// Valid/ready channels that carry operations into and results out of the queue.
// ----------------------------------------------------------------------------
interface sapq_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [sapq_pkg::PrioW-1:0]     prio_in;
  logic [sapq_pkg::PayloadW-1:0]  payload_in;

  modport source (output valid, func, prio_in, payload_in, input ready);
  modport sink (input valid, func, prio_in, payload_in, output ready);
endinterface

interface sapq_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [sapq_pkg::PrioW-1:0]     prio_out;
  logic [sapq_pkg::PayloadW-1:0]  payload_out;
  logic [sapq_pkg::CountW-1:0]    count_out;

  modport source (output valid, status, prio_out, payload_out, count_out, input ready);
  modport sink (input valid, status, prio_out, payload_out, count_out, output ready);
endinterface

/* rtl/sorted_array_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// The result of an item is registered and shown in the cycle after it is accepted.
// One item per cycle while no result stalls; all cells compare and shift at once.
// Reset clears the entry count and the result valid flag; cell contents and result
// data are not reset.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sapq_in_if.sink          in_i,
  sapq_out_if.source       out_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]    count_q, count_d;
  logic             out_valid_q;
  logic [1:0]       status_q, status_d;
  sapq_pkg::entry_t head_q, head_d;
  logic [sapq_pkg::CountW-1:0] cnt5_q;
  logic [CW+sapq_pkg::CountW-1:0] cnt_ext;

  logic             accept, full, empty;
  sapq_pkg::cell_ctrl_t ctrl;

  sapq_pkg::entry_t entries [DEPTH];
  logic [DEPTH-1:0] lower;
  logic [DEPTH-1:0] valid;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);

  assign ctrl.enq = accept && (in_i.func == sapq_pkg::FUNC_ENQ) && !full;
  assign ctrl.deq = accept && (in_i.func == sapq_pkg::FUNC_DEQ) && !empty;
  assign ctrl.new_entry.prio    = in_i.prio_in;
  assign ctrl.new_entry.payload = in_i.payload_in;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign valid[i] = (CW'(i) < count_q);
    sapq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (valid[i]),
      .prev_lower_i ((i == 0) ? 1'b0 : lower[(i == 0) ? 0 : i - 1]),
      .prev_entry_i (entries[(i == 0) ? 0 : i - 1]),
      .next_entry_i (entries[(i == DEPTH - 1) ? i : i + 1]),
      .entry_o      (entries[i]),
      .lower_o      (lower[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = sapq_pkg::STAT_OK;
    head_d   = '0;
    if (ctrl.enq) begin
      count_d = count_q + CW'(1);
    end else if (ctrl.deq) begin
      count_d = count_q - CW'(1);
      head_d  = entries[0];
    end else if (in_i.func == sapq_pkg::FUNC_ENQ) begin
      status_d = sapq_pkg::STAT_FULL;
    end else begin
      status_d = sapq_pkg::STAT_EMPTY;
    end
  end

  assign cnt_ext = {{sapq_pkg::CountW{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      head_q   <= head_d;
      cnt5_q   <= cnt_ext[sapq_pkg::CountW-1:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.prio_out    = head_q.prio;
  assign out_o.payload_out = head_q.payload;
  assign out_o.count_out   = cnt5_q;

endmodule

/* rtl/sapq_cell.sv */
// ----------------------------------------------------------------------------
// sapq_cell
// One storage cell of the sorted row: holds an entry and shifts or inserts.
// ----------------------------------------------------------------------------
module sapq_cell (
  input  logic                 clk_i,
  input  sapq_pkg::cell_ctrl_t ctrl_i,
  input  logic                 valid_i,
  input  logic                 prev_lower_i,
  input  sapq_pkg::entry_t     prev_entry_i,
  input  sapq_pkg::entry_t     next_entry_i,
  output sapq_pkg::entry_t     entry_o,
  output logic                 lower_o
);

  sapq_pkg::entry_t entry_q, entry_d;

  // An empty cell or one of strictly lower priority gives way to the new item.
  assign lower_o = !valid_i || (entry_q.prio < ctrl_i.new_entry.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq && lower_o) begin
      entry_d = prev_lower_i ? prev_entry_i : ctrl_i.new_entry;
    end else if (ctrl_i.deq) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* rtl/sapq_checker.sv */
// ----------------------------------------------------------------------------
// sapq_checker
// Port-level checks of the priority queue, bound to every instance.
// ----------------------------------------------------------------------------
`include "sorted_array_priority_queue_macros.svh"

module sapq_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic [1:0]                        status_i,
  input logic [sapq_pkg::PrioW-1:0]        prio_out_i,
  input logic [sapq_pkg::PayloadW-1:0]     payload_out_i,
  input logic [sapq_pkg::CountW-1:0]       count_out_i
);

  localparam logic [sapq_pkg::CountW-1:0] DepthLow = sapq_pkg::CountW'(DEPTH);

  `SAPQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i) && $stable(payload_out_i) && $stable(count_out_i), "stalled result changed")
  `SAPQ_ASSERT_NOW(a_stall_only_when_full, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i, "input stalled without a waiting result")
  `SAPQ_ASSERT_NOW(a_error_no_data, clk_i, rst_ni, out_valid_i && (status_i != sapq_pkg::STAT_OK), (prio_out_i == '0) && (payload_out_i == '0), "error result carries data")
  `SAPQ_ASSERT_NOW(a_full_count, clk_i, rst_ni, out_valid_i && (status_i == sapq_pkg::STAT_FULL), count_out_i == DepthLow, "full status with wrong count")
  `SAPQ_ASSERT_NOW(a_empty_count, clk_i, rst_ni, out_valid_i && (status_i == sapq_pkg::STAT_EMPTY), count_out_i == '0, "empty status with nonzero count")

endmodule

bind sorted_array_priority_queue sapq_checker #(
  .DEPTH (DEPTH)
) u_sapq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .prio_out_i    (out_o.prio_out),
  .payload_out_i (out_o.payload_out),
  .count_out_i   (out_o.count_out)
);

/* sim/sorted_array_priority_queue_tb.sv */
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_tb
// Self-checking regression of the sorted-array priority queue. A shadow copy
// of the queue predicts the result of every accepted operation, and each
// result is checked in order. The run opens with an empty dequeue, a fill,
// an overflow and a partial drain; random enqueue/dequeue streams swing the
// fill level between empty and full under several idle and stall patterns.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth      = 16;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    sapq_pkg::status_e                 status;
    logic [sapq_pkg::PrioW-1:0]        prio;
    logic [sapq_pkg::PayloadW-1:0]     payload;
    logic [sapq_pkg::CountW-1:0]       count;
  } pq_result_t;

  class pq_scoreboard;
    sapq_pkg::entry_t stored[$];
    pq_result_t  awaited[$];
    int unsigned errors  = 0;
    int unsigned n_enq   = 0;
    int unsigned n_deq   = 0;
    int unsigned n_full  = 0;
    int unsigned n_empty = 0;
    int unsigned peak    = 0;

    function void report(string msg);
      errors++;
      if (errors <= 10) begin
        $display("ERROR: %s", msg);
      end
    endfunction

    function void note_op(sapq_pkg::func_e op, sapq_pkg::entry_t e);
      pq_result_t  r;
      int unsigned pos;
      r = '0;
      r.status = sapq_pkg::STAT_OK;
      if (op == sapq_pkg::FUNC_ENQ) begin
        n_enq++;
        if (stored.size() >= Depth) begin
          r.status = sapq_pkg::STAT_FULL;
        end else begin
          pos = 0;
          while (pos < stored.size() && stored[pos].prio >= e.prio) begin
            pos++;
          end
          stored.insert(pos, e);
        end
      end else begin
        n_deq++;
        if (stored.size() == 0) begin
          r.status = sapq_pkg::STAT_EMPTY;
        end else begin
          r.prio    = stored[0].prio;
          r.payload = stored[0].payload;
          stored.delete(0);
        end
      end
      r.count = sapq_pkg::CountW'(stored.size());
      if (stored.size() > peak) begin
        peak = stored.size();
      end
      awaited.push_back(r);
    endfunction

    function void check_result(pq_result_t got);
      pq_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result: status %0d prio %h payload %h count %0d",
                         got.status, got.prio, got.payload, got.count));
        return;
      end
      want = awaited.pop_front();
      if (want.status == sapq_pkg::STAT_FULL) begin
        n_full++;
      end
      if (want.status == sapq_pkg::STAT_EMPTY) begin
        n_empty++;
      end
      if (got.status !== want.status || got.prio !== want.prio ||
          got.payload !== want.payload || got.count !== want.count) begin
        report($sformatf({"result mismatch: expected status %0d prio %h payload %h count %0d,",
                          " got status %0d prio %h payload %h count %0d"},
                         want.status, want.prio, want.payload, want.count,
                         got.status, got.prio, got.payload, got.count));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned cycle_cnt = 0;
  pq_scoreboard sb;

  sapq_in_if  op_ch ();
  sapq_out_if res_ch ();

  sorted_array_priority_queue #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_i  (op_ch),
    .out_o (res_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (op_ch.valid && op_ch.ready) begin
        sb.note_op(sapq_pkg::func_e'(op_ch.func), {op_ch.prio_in, op_ch.payload_in});
      end
      if (res_ch.valid && res_ch.ready) begin
        sb.check_result({sapq_pkg::status_e'(res_ch.status), res_ch.prio_out,
                         res_ch.payload_out, res_ch.count_out});
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("sorted_array_priority_queue regression: fail");
      $finish;
    end
  end

  task automatic send_op(input sapq_pkg::func_e op,
                         input logic [sapq_pkg::PrioW-1:0] prio,
                         input logic [sapq_pkg::PayloadW-1:0] payload);
    while ($urandom_range(0, 99) < idle_pct) begin
      op_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    op_ch.valid      <= 1'b1;
    op_ch.func       <= op;
    op_ch.prio_in    <= prio;
    op_ch.payload_in <= payload;
    do begin
      @(posedge clk_i);
    end while (!op_ch.ready);
  endtask

  function automatic logic [sapq_pkg::PrioW-1:0] pick_prio();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return sapq_pkg::PrioW'($urandom_range(0, 3));
      5:       return sapq_pkg::PrioW'($urandom_range(16'hFFFC, 16'hFFFF));
      default: return sapq_pkg::PrioW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic directed_ops();
    int unsigned k;
    send_op(sapq_pkg::FUNC_DEQ, '1, '1);
    send_op(sapq_pkg::FUNC_ENQ, 16'h0000, 32'h0000_0000);
    send_op(sapq_pkg::FUNC_ENQ, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(sapq_pkg::FUNC_ENQ, 16'h0000, 32'h0000_0001);
    for (k = 0; k < 13; k++) begin
      if (k < 4) begin
        send_op(sapq_pkg::FUNC_ENQ, 16'h8000, 32'hC0DE_0000 + k);
      end else begin
        send_op(sapq_pkg::FUNC_ENQ, sapq_pkg::PrioW'($urandom_range(0, 65535)), $urandom);
      end
    end
    send_op(sapq_pkg::FUNC_ENQ, 16'hFFFF, 32'h1234_5678);
    for (k = 0; k < 4; k++) begin
      send_op(sapq_pkg::FUNC_DEQ, '0, '0);
    end
  endtask

  task automatic random_ops(input int unsigned n_items);
    int unsigned k;
    int unsigned enq_pct;
    enq_pct = 50;
    for (k = 0; k < n_items; k++) begin
      if (k % 16 == 0) begin
        case ($urandom_range(0, 4))
          0:       enq_pct = 10;
          1:       enq_pct = 30;
          2:       enq_pct = 70;
          3:       enq_pct = 90;
          default: enq_pct = 50;
        endcase
      end
      if ($urandom_range(0, 99) < enq_pct) begin
        send_op(sapq_pkg::FUNC_ENQ, pick_prio(), $urandom);
      end else begin
        send_op(sapq_pkg::FUNC_DEQ, sapq_pkg::PrioW'($urandom_range(0, 65535)), $urandom);
      end
    end
  endtask

  initial begin
    int unsigned ph;
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    idle_tab  = '{0, 85, 0, 26};
    stall_tab = '{0, 0, 85, 26};
    sb = new;
    rst_ni           = 1'b0;
    idle_pct         = 0;
    stall_pct        = 0;
    op_ch.valid      = 1'b0;
    op_ch.func       = sapq_pkg::FUNC_ENQ;
    op_ch.prio_in    = '0;
    op_ch.payload_in = '0;
    res_ch.ready     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_ops();
    for (ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      random_ops(100);
    end
    op_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
    $display("Checked %0d enqueues and %0d dequeues; %0d refused as full, %0d found empty.",
             sb.n_enq, sb.n_deq, sb.n_full, sb.n_empty);
    $display("Deepest fill reached %0d of %0d entries; %0d errors.", sb.peak, Depth, sb.errors);
    if (sb.errors == 0) begin
      $display("sorted_array_priority_queue regression: pass");
    end else begin
      $display("sorted_array_priority_queue regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/sapq_pkg.sv
rtl/sapq_if.sv
rtl/sapq_cell.sv
rtl/sorted_array_priority_queue.sv
rtl/sapq_checker.sv
sim/sorted_array_priority_queue_tb.sv
